// ===== rtl/core/chip8_instruction_core_assert.svh =====
// Assertion macros for the instruction core.
`ifndef CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_ASSERT_SVH

// Same-cycle implication.
`define C8IC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define C8IC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/c8ic_pkg.sv =====
package c8ic_pkg;

  localparam int MEM_DEPTH_DEF     = 4096;
  localparam int STACK_DEPTH_DEF   = 16;
  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;

  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam logic [11:0] PC_RESET  = 12'h200;
  localparam int          FONT_LEN  = 80;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_EXEC = 2'd1;
  localparam logic [1:0] KIND_ROW  = 2'd2;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEI  = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDX  = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] MISC_GDT  = 8'h07;
  localparam logic [7:0] MISC_WKEY = 8'h0A;
  localparam logic [7:0] MISC_SDT  = 8'h15;
  localparam logic [7:0] MISC_SST  = 8'h18;
  localparam logic [7:0] MISC_ADDX = 8'h1E;
  localparam logic [7:0] MISC_FONT = 8'h29;
  localparam logic [7:0] MISC_BCD  = 8'h33;
  localparam logic [7:0] MISC_STR  = 8'h55;
  localparam logic [7:0] MISC_LDR  = 8'h65;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [3:0] FLAG_REG = 4'hF;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_F1, S_F2, S_VX, S_EXEC, S_WF, S_DRD, S_DWR, S_DEND,
    S_SR, S_SW, S_LR, S_LW, S_B0, S_B1, S_B2, S_ROW
  } state_t;

  typedef struct packed {
    logic       we;
    logic [7:0] val;
    logic       fwe;
    logic       flag;
  } alu_t;

  localparam logic [7:0] FONT_ROM [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [11:0] a);
    logic [11:0] off;
    logic [7:0]  res;
    off = a - FONT_BASE;
    res = 8'h00;
    if (a >= FONT_BASE && off < 12'(FONT_LEN)) begin
      res = FONT_ROM[off[6:0]];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/c8ic_ram.sv =====
module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/c8ic_alu.sv =====
module c8ic_alu import c8ic_pkg::*; (
  input  logic [3:0] op,
  input  logic [7:0] vx,
  input  logic [7:0] vy,
  output alu_t       res
);

  logic [8:0] sum;
  logic [8:0] dxy;
  logic [8:0] dyx;

  assign sum = {1'b0, vx} + {1'b0, vy};
  assign dxy = {1'b0, vx} - {1'b0, vy};
  assign dyx = {1'b0, vy} - {1'b0, vx};

  always_comb begin
    res = '{we: 1'b1, val: 8'h00, fwe: 1'b1, flag: 1'b0};
    unique case (op)
      ALU_MOV: begin
        res.val = vy;
        res.fwe = 1'b0;
      end
      ALU_OR:  res.val = vx | vy;
      ALU_AND: res.val = vx & vy;
      ALU_XOR: res.val = vx ^ vy;
      ALU_ADD: begin
        res.val  = sum[7:0];
        res.flag = sum[8];
      end
      ALU_SUB: begin
        res.val  = dxy[7:0];
        res.flag = ~dxy[8];
      end
      ALU_SHR: begin
        res.val  = {1'b0, vy[7:1]};
        res.flag = vy[0];
      end
      ALU_SBN: begin
        res.val  = dyx[7:0];
        res.flag = ~dyx[8];
      end
      ALU_SHL: begin
        res.val  = {vy[6:0], 1'b0};
        res.flag = vy[7];
      end
      default: begin
        res.we  = 1'b0;
        res.fwe = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/chip8_instruction_core.sv =====
// Load and unused kind finish in S_IDLE without raising busy; a row read passes S_ROW;
// instructions: S_F1, S_F2, S_VX, S_EXEC, then S_WF, draw, register copy or BCD states.
// Throughput: one transaction at a time, busy high until the done strobe; the
// strobe cycle itself accepts the next start. Memory and register RAM ports set the pace.
// Reset (rst, synchronous): clearing all MEM_DEPTH addresses loads the font, busy high.
// Results are not stalled: done marks each result for exactly one cycle.
module chip8_instruction_core import c8ic_pkg::*; #(
  parameter int MEM_DEPTH     = MEM_DEPTH_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       kind,
  input  logic [$clog2(MEM_DEPTH)-1:0]     load_address,
  input  logic [7:0]                       load_data,
  input  logic [15:0]                      keys_down,
  input  logic [7:0]                       random_byte,
  input  logic [$clog2(SCREEN_HEIGHT)-1:0] row_select,
  output logic                             done,
  output logic [$clog2(MEM_DEPTH)-1:0]     program_counter,
  output logic [15:0]                      last_opcode,
  output logic [SCREEN_WIDTH-1:0]          row_pixels,
  output logic                             screen_changed,
  output logic                             key_wait,
  output logic [7:0]                       sound_value,
  output logic [7:0]                       delay_value
);

  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int HW  = $clog2(SCREEN_HEIGHT);
  localparam int CW  = $clog2(SCREEN_WIDTH);

  state_t state, state_next;

  logic [AW-1:0]  clr, clr_next;
  logic [AW-1:0]  pc, pc_next;
  logic [AW-1:0]  idx, idx_next;
  logic [SPW-1:0] sp, sp_next, sp_inc, sp_dec;
  logic [7:0]     dly, dly_next, snd, snd_next;
  logic           awaitr, await_next;
  logic [3:0]     held, held_next;
  logic [15:0]    op, op_next;
  logic [7:0]     vx, vx_next, vy, vy_next;
  logic [15:0]    keys_q, keys_next;
  logic [7:0]     rnd_q, rnd_next;
  logic [3:0]     cnt, cnt_next;
  logic           hit, hit_next, chg, chg_next, wt, wt_next;
  logic           fin, fv_clr;

  logic [15:0]              rv;
  logic [STACK_DEPTH-1:0]   sv;
  logic [SCREEN_HEIGHT-1:0] fv;
  logic                     rvq, svq, fvq;

  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [7:0]    m_wdata, m_rdata;

  logic       r_we;
  logic [3:0] r_waddr, r_raddr;
  logic [7:0] r_wdata, r_rdata, reg_rd;

  logic           s_we;
  logic [SPW-1:0] s_waddr, s_raddr;
  logic [AW-1:0]  s_wdata, s_rdata, stk_rd;

  logic                    f_we;
  logic [HW-1:0]           f_waddr, f_raddr;
  logic [SCREEN_WIDTH-1:0] f_wdata, f_rdata, frm_rd, spr_bits, row_v;

  logic [3:0]  x, y, n;
  logic [7:0]  kk;
  logic [AW-1:0] nnn;
  logic [HW:0] r6;
  logic [3:0]  first_key;
  logic        any_key;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [3:0]  ones;
  alu_t        alu;

  c8ic_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  c8ic_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  c8ic_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_frame (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  c8ic_alu u_alu (.op(op[3:0]), .vx(vx), .vy(reg_rd), .res(alu));

  assign x      = op[11:8];
  assign y      = op[7:4];
  assign n      = op[3:0];
  assign kk     = op[7:0];
  assign nnn    = op[AW-1:0];
  assign reg_rd = rvq ? r_rdata : 8'h00;
  assign stk_rd = svq ? s_rdata : '0;
  assign frm_rd = fvq ? f_rdata : '0;
  assign sp_inc = (sp == SPW'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  assign sp_dec = (sp == '0) ? SPW'(STACK_DEPTH - 1) : sp - 1'b1;
  assign r6     = (HW + 1)'(vy[HW-1:0]) + (HW + 1)'(cnt);
  assign spr_bits = {m_rdata, (SCREEN_WIDTH - 8)'(0)} >> vx[CW-1:0];

  assign hund = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
  assign rem  = 7'(vx - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0)));
  assign prod = 15'(rem) * 15'd205;
  assign tens = prod[14:11];
  assign ones = 4'(rem - 7'(tens) * 7'd10);

  always_comb begin
    first_key = 4'h0;
    any_key   = 1'b0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) begin
        first_key = 4'(k);
        any_key   = 1'b1;
      end
    end
  end

  assign busy            = (state != S_IDLE);
  assign program_counter = pc;
  assign sound_value     = snd;
  assign delay_value     = dly;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      clr    <= '0;
      pc     <= PC_RESET[AW-1:0];
      idx    <= '0;
      sp     <= '0;
      dly    <= 8'h00;
      snd    <= 8'h00;
      awaitr <= 1'b0;
      held   <= 4'h0;
      rv     <= '0;
      sv     <= '0;
      fv     <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      clr    <= clr_next;
      pc     <= pc_next;
      idx    <= idx_next;
      sp     <= sp_next;
      dly    <= dly_next;
      snd    <= snd_next;
      awaitr <= await_next;
      held   <= held_next;
      done   <= fin;
      if (r_we) begin
        rv[r_waddr] <= 1'b1;
      end
      if (s_we) begin
        sv[s_waddr] <= 1'b1;
      end
      if (fv_clr) begin
        fv <= '0;
      end else if (f_we) begin
        fv[f_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    vx     <= vx_next;
    vy     <= vy_next;
    keys_q <= keys_next;
    rnd_q  <= rnd_next;
    cnt    <= cnt_next;
    hit    <= hit_next;
    chg    <= chg_next;
    wt     <= wt_next;
    rvq    <= rv[r_raddr];
    svq    <= sv[s_raddr];
    fvq    <= fv[f_raddr];
    if (fin) begin
      last_opcode    <= op_next;
      row_pixels     <= row_v;
      screen_changed <= chg_next;
      key_wait       <= wt_next;
    end
  end

  always_comb begin
    state_next = state;
    clr_next   = clr;
    pc_next    = pc;
    idx_next   = idx;
    sp_next    = sp;
    dly_next   = dly;
    snd_next   = snd;
    await_next = awaitr;
    held_next  = held;
    op_next    = op;
    vx_next    = vx;
    vy_next    = vy;
    keys_next  = keys_q;
    rnd_next   = rnd_q;
    cnt_next   = cnt;
    hit_next   = hit;
    chg_next   = chg;
    wt_next    = wt;
    fin        = 1'b0;
    fv_clr     = 1'b0;
    row_v      = '0;
    m_we       = 1'b0;
    m_waddr    = '0;
    m_wdata    = 8'h00;
    m_raddr    = pc;
    r_we       = 1'b0;
    r_waddr    = x;
    r_wdata    = 8'h00;
    r_raddr    = x;
    s_we       = 1'b0;
    s_waddr    = sp_inc;
    s_wdata    = pc + AW'(2);
    s_raddr    = sp;
    f_we       = 1'b0;
    f_waddr    = r6[HW-1:0];
    f_wdata    = frm_rd ^ spr_bits;
    f_raddr    = r6[HW-1:0];

    unique case (state)
      S_CLEAR: begin
        m_we     = 1'b1;
        m_waddr  = clr;
        m_wdata  = font_byte(12'(clr));
        clr_next = clr + 1'b1;
        if (clr == AW'(MEM_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          keys_next = keys_down;
          rnd_next  = random_byte;
          op_next   = 16'h0000;
          chg_next  = 1'b0;
          wt_next   = 1'b0;
          unique case (kind)
            KIND_LOAD: begin
              m_we    = 1'b1;
              m_waddr = load_address;
              m_wdata = load_data;
              fin     = 1'b1;
            end
            KIND_EXEC: begin
              m_raddr    = pc;
              state_next = S_F1;
            end
            KIND_ROW: begin
              f_raddr    = row_select;
              state_next = S_ROW;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_ROW: begin
        row_v      = frm_rd;
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_F1: begin
        m_raddr       = pc + AW'(1);
        op_next[15:8] = m_rdata;
        state_next    = S_F2;
      end
      S_F2: begin
        op_next[7:0] = m_rdata;
        r_raddr      = x;
        state_next   = S_VX;
      end
      S_VX: begin
        vx_next    = reg_rd;
        r_raddr    = (op[15:12] == GRP_JPV0) ? 4'h0 : y;
        s_raddr    = sp;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        vy_next    = reg_rd;
        pc_next    = pc + AW'(2);
        fin        = 1'b1;
        state_next = S_IDLE;
        unique case (op[15:12])
          GRP_SYS: begin
            if (op == OPC_CLS) begin
              fv_clr   = 1'b1;
              chg_next = 1'b1;
            end else if (op == OPC_RET) begin
              pc_next = stk_rd;
              sp_next = sp_dec;
            end
          end
          GRP_JP: pc_next = nnn;
          GRP_CALL: begin
            s_we    = 1'b1;
            sp_next = sp_inc;
            pc_next = nnn;
          end
          GRP_SEI:  if (vx == kk) pc_next = pc + AW'(4);
          GRP_SNEI: if (vx != kk) pc_next = pc + AW'(4);
          GRP_SER:  if (vx == reg_rd) pc_next = pc + AW'(4);
          GRP_SNER: if (vx != reg_rd) pc_next = pc + AW'(4);
          GRP_LDI: begin
            r_we    = 1'b1;
            r_wdata = kk;
          end
          GRP_ADDI: begin
            r_we    = 1'b1;
            r_wdata = vx + kk;
          end
          GRP_ALU: begin
            r_we    = alu.we;
            r_wdata = alu.val;
            if (alu.fwe) begin
              hit_next   = alu.flag;
              fin        = 1'b0;
              state_next = S_WF;
            end
          end
          GRP_LDX:  idx_next = nnn;
          GRP_JPV0: pc_next = nnn + AW'(reg_rd);
          GRP_RND: begin
            r_we    = 1'b1;
            r_wdata = rnd_q & kk;
          end
          GRP_DRW: begin
            cnt_next   = 4'h0;
            hit_next   = 1'b0;
            chg_next   = 1'b1;
            fin        = 1'b0;
            state_next = S_DRD;
          end
          GRP_KEY: begin
            if (kk == KEY_SKP && keys_q[vx[3:0]]) begin
              pc_next = pc + AW'(4);
            end else if (kk == KEY_SKNP && !keys_q[vx[3:0]]) begin
              pc_next = pc + AW'(4);
            end
          end
          GRP_MISC: begin
            unique case (kk)
              MISC_GDT: begin
                r_we    = 1'b1;
                r_wdata = dly;
              end
              MISC_WKEY: begin
                if (awaitr && !keys_q[held]) begin
                  r_we       = 1'b1;
                  r_wdata    = {4'h0, held};
                  await_next = 1'b0;
                end else begin
                  pc_next = pc;
                  wt_next = 1'b1;
                  if (!awaitr && any_key) begin
                    held_next  = first_key;
                    await_next = 1'b1;
                  end
                end
              end
              MISC_SDT:  dly_next = vx;
              MISC_SST:  snd_next = vx;
              MISC_ADDX: idx_next = idx + AW'(vx);
              MISC_FONT: idx_next = FONT_BASE[AW-1:0] + AW'({vx, 2'b00}) + AW'(vx);
              MISC_BCD: begin
                fin        = 1'b0;
                state_next = S_B0;
              end
              MISC_STR: begin
                cnt_next   = 4'h0;
                fin        = 1'b0;
                state_next = S_SR;
              end
              MISC_LDR: begin
                cnt_next   = 4'h0;
                fin        = 1'b0;
                state_next = S_LR;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_WF: begin
        r_we       = 1'b1;
        r_waddr    = FLAG_REG;
        r_wdata    = {7'h00, hit};
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_DRD: begin
        if (cnt == n || r6[HW]) begin
          state_next = S_DEND;
        end else begin
          m_raddr    = idx + AW'(cnt);
          state_next = S_DWR;
        end
      end
      S_DWR: begin
        f_we       = 1'b1;
        hit_next   = hit | (|(frm_rd & spr_bits));
        cnt_next   = cnt + 1'b1;
        state_next = S_DRD;
      end
      S_DEND: begin
        r_we       = 1'b1;
        r_waddr    = FLAG_REG;
        r_wdata    = {7'h00, hit};
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_SR: begin
        r_raddr    = cnt;
        state_next = S_SW;
      end
      S_SW: begin
        m_we    = 1'b1;
        m_waddr = idx + AW'(cnt);
        m_wdata = reg_rd;
        if (cnt == x) begin
          idx_next   = idx + AW'(x) + AW'(1);
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_SR;
        end
      end
      S_LR: begin
        m_raddr    = idx + AW'(cnt);
        state_next = S_LW;
      end
      S_LW: begin
        r_we    = 1'b1;
        r_waddr = cnt;
        r_wdata = m_rdata;
        if (cnt == x) begin
          idx_next   = idx + AW'(x) + AW'(1);
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_LR;
        end
      end
      S_B0: begin
        m_we       = 1'b1;
        m_waddr    = idx;
        m_wdata    = {6'h00, hund};
        state_next = S_B1;
      end
      S_B1: begin
        m_we       = 1'b1;
        m_waddr    = idx + AW'(1);
        m_wdata    = {4'h0, tens};
        state_next = S_B2;
      end
      S_B2: begin
        m_we       = 1'b1;
        m_waddr    = idx + AW'(2);
        m_wdata    = {4'h0, ones};
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `include "chip8_instruction_core_assert.svh"

  `C8IC_ASSERT_NOW(a_sp_range, 1'b1, int'(sp) < STACK_DEPTH)
  `C8IC_ASSERT_NOW(a_no_done_in_clear, state == S_CLEAR, !fin)
  `C8IC_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done)
  `C8IC_ASSERT_NEXT(a_jump_target, state == S_EXEC && op[15:12] == GRP_JP, done && program_counter == $past(op[AW-1:0]))

endmodule
